/* design/sbsc_pkg.sv */
// Types, constants and helper functions for the six-by-six bigram square cipher.
// No dependencies; imported by six_by_six_bigram_square_cipher_top.
package sbsc_pkg;

    localparam int unsigned NUM_SYM  = 36;
    localparam int unsigned SYM_W    = 6;
    localparam logic [5:0]  SYM_X    = 6'd23;
    localparam logic [5:0]  SYM_LAST = 6'd35;
    localparam logic [5:0]  FULL_CNT = 6'd36;
    localparam logic [7:0]  CH_A     = 8'h41;   // 'A'
    localparam logic [7:0]  CH_Z     = 8'h5A;   // 'Z'
    localparam logic [7:0]  CH_LA    = 8'h61;   // 'a'
    localparam logic [7:0]  CH_LZ    = 8'h7A;   // 'z'
    localparam logic [7:0]  CH_0     = 8'h30;   // '0'
    localparam logic [7:0]  CH_9     = 8'h39;   // '9'
    localparam logic        REQ_KEY  = 1'b0;
    localparam logic        REQ_MSG  = 1'b1;

    typedef logic [SYM_W-1:0] sym_t;

    typedef struct packed {
        logic ok;
        sym_t sym;
    } sym_lookup_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOK_A,
        ST_LOOK_B,
        ST_CELL_0,
        ST_CELL_1,
        ST_CELL_2,
        ST_SEND_0,
        ST_SEND_1
    } state_t;

    function automatic sym_lookup_t to_symbol(input logic [7:0] c, input logic fold);
        sym_lookup_t r;
        logic [7:0]  d;
        r = '{ok: 1'b0, sym: '0};
        if (c >= CH_A && c <= CH_Z) begin
            d = c - CH_A;
            r = '{ok: 1'b1, sym: d[5:0]};
        end else if (fold && c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA;
            r = '{ok: 1'b1, sym: d[5:0]};
        end else if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0 + 8'd26;
            r = '{ok: 1'b1, sym: d[5:0]};
        end
        return r;
    endfunction

    function automatic logic [7:0] to_ascii(input sym_t s);
        logic [7:0] r;
        if (s < 6'd26) r = CH_A + {2'b00, s};
        else           r = CH_0 + {2'b00, s} - 8'd26;
        return r;
    endfunction

    // pos / 6 for pos < 36: (pos * 43) >> 8
    function automatic logic [2:0] pos_row(input sym_t p);
        logic [11:0] prod;
        prod = {6'd0, p} * 12'd43;
        return prod[10:8];
    endfunction

    function automatic logic [2:0] pos_col(input sym_t p);
        logic [5:0] r6;
        r6 = {3'd0, pos_row(p)};
        return 3'(p - ((r6 << 2) + (r6 << 1)));
    endfunction

    function automatic sym_t cell_index(input logic [2:0] row, input logic [2:0] col);
        logic [5:0] r6;
        r6 = {3'd0, row};
        return (r6 << 2) + (r6 << 1) + {3'd0, col};
    endfunction

endpackage

/* design/six_by_six_bigram_square_cipher_top.sv */
// Six-by-six bigram square cipher: key square build and pair encryption.
// Depends on sbsc_pkg.
//
//  channel | ports                              | contents
//  s_      | s_tvalid s_tready s_tdata s_tuser  | tdata[7:0] in_byte, tuser req_type,
//          | s_tlast                            | tlast is_final
//  m_      | m_tvalid m_tready m_tdata m_tlast  | tdata[7:0] out_char, tlast end_of_text
//
// Keyword byte: the final keyword byte adds a fill walk over all 36 symbols.
// Message byte: when a pair completes, single-port reads (two position reads, two cell
// reads) run in ST_LOOK_A to ST_CELL_2, then each result item is held until taken.
// s_tready is high only in the idle state; a stalled m_ side holds the block.
// Reset (aresetn low, synchronous) clears the key; the square memories need no clearing.
module six_by_six_bigram_square_cipher_top
    import sbsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tuser,    // [0] req_type
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_char
    output logic       m_tlast
);

    sym_t       cell_mem [NUM_SYM];
    sym_t       pos_mem  [NUM_SYM];

    state_t     state_reg, state_next;
    logic [35:0] seen_reg, seen_next;
    sym_t       fill_reg, fill_next;
    sym_t       walk_reg, walk_next;
    sym_t       pend_reg, pend_next;
    logic       pend_vld_reg, pend_vld_next;
    sym_t       a_reg, a_next;
    sym_t       b_reg, b_next;
    sym_t       pa_reg, pa_next;
    sym_t       pb_reg, pb_next;
    logic       last_reg, last_next;
    logic [7:0] ch0_reg, ch0_next;
    logic [7:0] ch1_reg, ch1_next;

    sym_t       pos_rd_reg, cell_rd_reg;
    sym_t       pos_addr, cell_addr;
    logic       wr_en;
    sym_t       wr_sym;

    sym_lookup_t key_sym, msg_sym;
    logic        accept, key_done;

    assign accept   = s_tvalid && s_tready;
    assign key_done = (fill_reg == FULL_CNT);
    assign key_sym  = to_symbol(s_tdata, 1'b0);
    assign msg_sym  = to_symbol(s_tdata, 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seen_reg     <= '0;
            fill_reg     <= '0;
            walk_reg     <= '0;
            pend_reg     <= '0;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            fill_reg     <= fill_next;
            walk_reg     <= walk_next;
            pend_reg     <= pend_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        last_reg <= last_next;
        ch0_reg  <= ch0_next;
        ch1_reg  <= ch1_next;
    end

    // square and symbol-position stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cell_mem[fill_reg] <= wr_sym;
            pos_mem[wr_sym]    <= fill_reg;
        end
        pos_rd_reg  <= pos_mem[pos_addr];
        cell_rd_reg <= cell_mem[cell_addr];
    end

    always_comb begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        fill_next     = fill_reg;
        walk_next     = walk_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        last_next     = last_reg;
        ch0_next      = ch0_reg;
        ch1_next      = ch1_reg;
        wr_en         = 1'b0;
        wr_sym        = key_sym.sym;
        pos_addr      = a_reg;
        cell_addr     = cell_index(pos_row(pa_reg), pos_col(pb_reg));
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        m_tdata       = ch1_reg;
        m_tlast       = last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept && s_tuser == REQ_KEY && !key_done) begin
                    if (key_sym.ok && !seen_reg[key_sym.sym]) begin
                        wr_en                  = 1'b1;
                        seen_next[key_sym.sym] = 1'b1;
                        fill_next              = fill_reg + 6'd1;
                    end
                    if (s_tlast) begin
                        walk_next  = '0;
                        state_next = ST_FILL;
                    end
                end else if (accept && s_tuser == REQ_MSG && key_done) begin
                    last_next = s_tlast;
                    priority if (msg_sym.ok && pend_vld_reg) begin
                        a_next        = pend_reg;
                        b_next        = msg_sym.sym;
                        pend_vld_next = 1'b0;
                        state_next    = ST_LOOK_A;
                    end else if (msg_sym.ok && s_tlast) begin
                        a_next     = msg_sym.sym;
                        b_next     = SYM_X;
                        state_next = ST_LOOK_A;
                    end else if (msg_sym.ok) begin
                        pend_next     = msg_sym.sym;
                        pend_vld_next = 1'b1;
                    end else if (s_tlast && pend_vld_reg) begin
                        a_next        = pend_reg;
                        b_next        = SYM_X;
                        pend_vld_next = 1'b0;
                        state_next    = ST_LOOK_A;
                    end else if (s_tlast) begin
                        // nothing produced: lone terminator item
                        ch1_next   = 8'd0;
                        state_next = ST_SEND_1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FILL: begin
                // remaining cells take unused symbols in code order
                wr_sym = walk_reg;
                if (!key_done && !seen_reg[walk_reg]) begin
                    wr_en               = 1'b1;
                    seen_next[walk_reg] = 1'b1;
                    fill_next           = fill_reg + 6'd1;
                end
                walk_next = walk_reg + 6'd1;
                if (walk_reg == SYM_LAST) state_next = ST_IDLE;
            end
            ST_LOOK_A: begin
                pos_addr   = a_reg;
                state_next = ST_LOOK_B;
            end
            ST_LOOK_B: begin
                pos_addr   = b_reg;
                pa_next    = pos_rd_reg;
                state_next = ST_CELL_0;
            end
            ST_CELL_0: begin
                pb_next    = pos_rd_reg;
                cell_addr  = cell_index(pos_row(pa_reg), pos_col(pos_rd_reg));
                state_next = ST_CELL_1;
            end
            ST_CELL_1: begin
                ch0_next   = to_ascii(cell_rd_reg);
                cell_addr  = cell_index(pos_row(pb_reg), pos_col(pa_reg));
                state_next = ST_CELL_2;
            end
            ST_CELL_2: begin
                ch1_next   = to_ascii(cell_rd_reg);
                state_next = ST_SEND_0;
            end
            ST_SEND_0: begin
                m_tvalid = 1'b1;
                m_tdata  = ch0_reg;
                m_tlast  = 1'b0;
                if (m_tready) state_next = ST_SEND_1;
            end
            ST_SEND_1: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* sim/tb_six_by_six_bigram_square_cipher_top.sv */
// Self-checking testbench for six_by_six_bigram_square_cipher_top: builds one key square,
// then streams message text while a scoreboard predicts every cipher item and compares.
// Depends on sbsc_pkg and the cipher top level.
module tb_six_by_six_bigram_square_cipher_top
    import sbsc_pkg::*;
();

    localparam int         MSG_ITEMS  = 1900;
    localparam int         IDLE_LIMIT = 400;
    localparam int         TAIL       = 20;
    localparam int         SQ_CELLS   = 36;
    localparam logic [5:0] PAD_SYM    = 6'd23;    // X
    localparam logic [7:0] UP_A   = 8'h41;
    localparam logic [7:0] UP_Z   = 8'h5A;
    localparam logic [7:0] LOW_A  = 8'h61;
    localparam logic [7:0] LOW_Z  = 8'h7A;
    localparam logic [7:0] DIG_0  = 8'h30;
    localparam logic [7:0] DIG_9  = 8'h39;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } cipher_item_t;

    class cipher_scoreboard;
        logic [5:0]   cell_sym[SQ_CELLS];
        logic [5:0]   sym_cell[SQ_CELLS];
        logic [35:0]  placed;
        int           filled;
        logic [5:0]   held_sym;
        bit           held;
        cipher_item_t expected_cipher[$];
        int           mismatches;

        function new();
            placed     = '0;
            filled     = 0;
            held_sym   = '0;
            held       = 1'b0;
            mismatches = 0;
        endfunction

        function bit map_symbol(input logic [7:0] c, input bit fold, output logic [5:0] s);
            s = '0;
            if (c >= UP_A && c <= UP_Z) begin
                s = 6'(c - UP_A);
                return 1'b1;
            end
            if (fold && c >= LOW_A && c <= LOW_Z) begin
                s = 6'(c - LOW_A);
                return 1'b1;
            end
            if (c >= DIG_0 && c <= DIG_9) begin
                s = 6'(c - DIG_0 + 8'd26);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [7:0] symbol_char(input logic [5:0] s);
            if (s < 6'd26) return UP_A + 8'(s);
            return DIG_0 + 8'(s) - 8'd26;
        endfunction

        function void place_symbol(input logic [5:0] s);
            if (filled >= SQ_CELLS || placed[s]) return;
            cell_sym[filled] = s;
            sym_cell[s]      = 6'(filled);
            placed[s]        = 1'b1;
            filled++;
        endfunction

        // opposite corners of the rectangle spanned by the two symbols
        function void push_pair(input logic [5:0] a, input logic [5:0] b);
            int pa;
            int pb;
            pa = sym_cell[a];
            pb = sym_cell[b];
            expected_cipher.push_back('{symbol_char(cell_sym[(pa / 6) * 6 + pb % 6]), 1'b0});
            expected_cipher.push_back('{symbol_char(cell_sym[(pb / 6) * 6 + pa % 6]), 1'b0});
        endfunction

        function void note_input(input logic req, input logic [7:0] c, input logic fin);
            logic [5:0] s;
            int         produced;
            produced = 0;
            if (req == REQ_KEY) begin
                if (filled >= SQ_CELLS) return;
                if (map_symbol(c, 1'b0, s)) place_symbol(s);
                if (fin) for (int k = 0; k < SQ_CELLS; k++) place_symbol(6'(k));
                return;
            end
            if (filled < SQ_CELLS) return;
            if (map_symbol(c, 1'b1, s)) begin
                if (held) begin
                    push_pair(held_sym, s);
                    produced = 2;
                    held     = 1'b0;
                end else begin
                    held_sym = s;
                    held     = 1'b1;
                end
            end
            if (fin) begin
                if (held) begin
                    push_pair(held_sym, PAD_SYM);
                    produced += 2;
                    held = 1'b0;
                end
                if (produced == 0)
                    expected_cipher.push_back('{8'h00, 1'b1});
                else
                    expected_cipher[expected_cipher.size() - 1].eot = 1'b1;
            end
        endfunction

        task report(input string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_cipher(input logic [7:0] ch, input logic eot);
            cipher_item_t e;
            if (expected_cipher.size() == 0) begin
                report($sformatf("unexpected item char=%02h last=%b", ch, eot));
                return;
            end
            e = expected_cipher.pop_front();
            if (ch !== e.ch) report($sformatf("char %02h, want %02h", ch, e.ch));
            if (eot !== e.eot) report($sformatf("last %b, want %b (char %02h)", eot, e.eot, e.ch));
        endtask
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    cipher_scoreboard sb = new();
    int burst_left  = 0;
    int ready_left  = 0;
    logic ready_lvl = 1'b0;
    int stall_cycles = 0;

    six_by_six_bigram_square_cipher_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // receiver: short stalls mixed with long free-running stretches
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    ready_lvl  = 1'b1;
                    ready_left = $urandom_range(20, 60);
                end
                2, 3, 4, 5: begin
                    ready_lvl  = 1'b1;
                    ready_left = $urandom_range(1, 4);
                end
                default: begin
                    ready_lvl  = 1'b0;
                    ready_left = $urandom_range(1, 8);
                end
            endcase
        end
        ready_left--;
        m_tready <= ready_lvl;
    end

    // handshake monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_cipher(m_tdata, m_tlast);
        if ((aresetn && s_tvalid && s_tready) || (aresetn && m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_item(input logic req, input logic [7:0] b, input logic fin);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic drain_cipher();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.expected_cipher.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return sb.symbol_char(6'($urandom_range(0, 35)));
            5, 6:          return LOW_A + 8'($urandom_range(0, 25));
            default:       return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [5:0] order[SQ_CELLS];
        logic [5:0] tmp;
        logic [7:0] b;
        logic       fin;
        int         j;
        int         fed;
        int         n_key;

        fed = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // message text before the key is complete is dropped, final flag too
        send_item(REQ_MSG, "H", 1'b0);
        send_item(REQ_MSG, "i", 1'b0);
        send_item(REQ_MSG, "!", 1'b1);

        // key: upper/lower case, field extremes, repeats and noise
        send_item(REQ_KEY, "Z", 1'b0);
        send_item(REQ_KEY, "z", 1'b0);
        send_item(REQ_KEY, 8'h00, 1'b0);
        send_item(REQ_KEY, "9", 1'b0);
        send_item(REQ_KEY, "Z", 1'b0);
        send_item(REQ_KEY, 8'hFF, 1'b0);
        send_item(REQ_KEY, "0", 1'b0);
        send_item(REQ_KEY, "@", 1'b0);
        send_item(REQ_KEY, "A", 1'b0);

        if ($urandom_range(0, 3) == 0) begin
            // every symbol spelt out: key completes with no final byte
            for (int i = 0; i < SQ_CELLS; i++) order[i] = 6'(i);
            for (int i = SQ_CELLS - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < SQ_CELLS; i++) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(REQ_KEY, LOW_A + 8'($urandom_range(0, 25)), 1'b0);
                send_item(REQ_KEY, sb.symbol_char(order[i]), 1'b0);
            end
        end else begin
            n_key = $urandom_range(0, 20);
            for (int i = 0; i < n_key; i++) send_item(REQ_KEY, random_text_byte(), 1'b0);
            send_item(REQ_KEY, random_text_byte(), 1'b1);
        end

        // key is complete now: further key bytes are ignored
        send_item(REQ_KEY, "Q", 1'b0);
        send_item(REQ_KEY, "R", 1'b1);

        // odd length padded with X
        send_item(REQ_MSG, "A", 1'b1);
        send_item(REQ_MSG, "H", 1'b0);
        send_item(REQ_MSG, "I", 1'b1);
        // empty message gives the terminator item
        send_item(REQ_MSG, "!", 1'b1);
        // same letter twice, then an open digit closed by a non-symbol final
        send_item(REQ_MSG, "b", 1'b0);
        send_item(REQ_MSG, "B", 1'b0);
        send_item(REQ_MSG, "7", 1'b0);
        send_item(REQ_MSG, 8'h00, 1'b0);
        send_item(REQ_MSG, "#", 1'b1);
        send_item(REQ_MSG, 8'hFF, 1'b1);
        send_item(REQ_MSG, "x", 1'b0);
        send_item(REQ_MSG, "z", 1'b0);
        send_item(REQ_MSG, "0", 1'b0);
        send_item(REQ_MSG, "9", 1'b1);
        drain_cipher();

        while (fed < MSG_ITEMS) begin
            if ($urandom_range(0, 29) == 0) begin
                send_item(REQ_KEY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                b   = random_text_byte();
                fin = ($urandom_range(0, 9) == 0);
                send_item(REQ_MSG, b, fin);
                fed++;
                if (fin && $urandom_range(0, 15) == 0) drain_cipher();
            end
        end

        drain_cipher();
        repeat (TAIL) @(posedge aclk);
        if (sb.expected_cipher.size() != 0)
            sb.report($sformatf("%0d items never arrived", sb.expected_cipher.size()));
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
design/sbsc_pkg.sv
design/six_by_six_bigram_square_cipher_top.sv
sim/tb_six_by_six_bigram_square_cipher_top.sv
